// ----- rtl/qog_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qog_pkg: shared definitions of the quadrature oscillator with glide
// Field widths, register indexes, reset values and the payload structs of
// the request and sample channels.
// ----------------------------------------------------------------------------
package qog_pkg;

  localparam int BLOCK_MAX_DEFAULT = 64;

  localparam int LEN_W     = 7;
  localparam int STEP_W    = 32;
  localparam int DATA_W    = 32;
  localparam int DELAY_W   = 24;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_BITS = 30;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_SINE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_COSINE = 2'd2;

  localparam logic [DELAY_W-1:0]       DELAY_RESET        = 24'd0;
  localparam logic signed [DATA_W-1:0] START_SINE_RESET   = 32'sd0;
  localparam logic signed [DATA_W-1:0] START_COSINE_RESET = 32'sd536870912;

  typedef struct packed {
    logic [LEN_W-1:0]  block_len;
    logic [STEP_W-1:0] step_factor;
  } qog_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     last;
  } qog_out_t;

  typedef struct packed {
    logic [DELAY_W-1:0]       delay_samples;
    logic signed [DATA_W-1:0] start_sine;
    logic signed [DATA_W-1:0] start_cosine;
  } qog_cfg_t;

endpackage

// ----- rtl/qog_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qog_div: iterative restoring divider
// Produces one quotient bit per cycle for an unsigned dividend and divisor.
// ----------------------------------------------------------------------------
module qog_div #(
  parameter int NW = 39,
  parameter int DW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [NW-1:0]    quo_q, quo_d;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             fits;

  assign trial = {rem_q, quo_q[NW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NW);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
      quo_d = {quo_q[NW-2:0], fits};
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/qog_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qog_core: sequencer and shared multiplier of the oscillator
// Walks each block sample by sample, drives the divider for the glide and
// reuses one multiplier for the span product and both phase updates.
// ----------------------------------------------------------------------------
module qog_core #(
  parameter int BLOCK_MAX = qog_pkg::BLOCK_MAX_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qog_pkg::qog_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  qog_pkg::qog_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output qog_pkg::qog_out_t out_data_o
);

  localparam int CW = $clog2(BLOCK_MAX + 1);
  localparam int NW = CW + qog_pkg::STEP_W;
  localparam int SW = qog_pkg::STEP_W;
  localparam int DWD = qog_pkg::DATA_W;
  localparam int PW = SW + DWD + 1;
  localparam int DLW = qog_pkg::DELAY_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SILENT = 4'd1;
  localparam logic [3:0] S_PREP   = 4'd2;
  localparam logic [3:0] S_SPAN   = 4'd3;
  localparam logic [3:0] S_NUMI   = 4'd4;
  localparam logic [3:0] S_SAMPLE = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_MULS   = 4'd7;
  localparam logic [3:0] S_UPDC   = 4'd8;
  localparam logic [3:0] S_MULC   = 4'd9;
  localparam logic [3:0] S_UPDS   = 4'd10;
  localparam logic [3:0] S_EMIT   = 4'd11;

  function automatic logic signed [DWD-1:0] sat32(input logic signed [DWD+3:0] x);
    logic signed [DWD-1:0] r;
    if (x > 36'sh07FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (x < 36'shF80000000) begin
      r = 32'sh80000000;
    end else begin
      r = x[DWD-1:0];
    end
    return r;
  endfunction

  logic [3:0]            state_q, state_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         len_q, len_d;
  logic [CW-1:0]         sil_q, sil_d;
  logic [CW-1:0]         span_q, span_d;
  logic [SW-1:0]         step_q, step_d;
  logic [SW-1:0]         old_q, old_d;
  logic [SW-1:0]         cur_step_q, cur_step_d;
  logic [SW-1:0]         e_q, e_d;
  logic                  started_q, started_d;
  logic                  glide_q, glide_d;
  logic signed [DWD-1:0] sine_q, sine_d;
  logic signed [DWD-1:0] cos_q, cos_d;
  logic signed [PW-1:0]  prod_q, prod_d;
  logic [NW-1:0]         num_q, num_d;
  logic [DLW-1:0]        dcount_q, dcount_d;
  logic                  out_valid_q, out_valid_d;
  qog_pkg::qog_out_t     out_q, out_d;

  logic                  out_free;
  logic                  accept;
  logic [CW-1:0]         len_sat;
  logic [DLW-1:0]        remain;
  logic [CW-1:0]         silent;
  logic                  is_last;
  logic [SW-1:0]         mul_a;
  logic signed [DWD-1:0] mul_b;
  logic signed [PW-1:0]  mul_p;
  logic signed [PW-31:0] scaled;
  logic                  div_start;
  logic                  div_done;
  logic [NW-1:0]         div_quo;

  qog_div #(
    .NW(NW),
    .DW(CW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(num_q),
    .divisor_i (span_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_last    = idx_q == CW'(len_q - 1'b1);

  assign len_sat = (in_data_i.block_len > qog_pkg::LEN_W'(BLOCK_MAX)) ?
                   CW'(BLOCK_MAX) : in_data_i.block_len[CW-1:0];
  assign remain  = (dcount_q < cfg_i.delay_samples) ? cfg_i.delay_samples - dcount_q : '0;
  assign silent  = (remain < DLW'(len_sat)) ? remain[CW-1:0] : len_sat;

  assign mul_a  = (state_q == S_SPAN) ? old_q : e_q;
  assign mul_b  = (state_q == S_SPAN) ? $signed(DWD'(span_q)) :
                  (state_q == S_MULS) ? sine_q : cos_q;
  assign mul_p  = PW'($signed({1'b0, mul_a})) * PW'(mul_b);
  assign scaled = prod_q[PW-1:qog_pkg::FRAC_BITS];

  assign div_start = (state_q == S_SAMPLE) && glide_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    len_d       = len_q;
    sil_d       = sil_q;
    span_d      = span_q;
    step_d      = step_q;
    old_d       = old_q;
    cur_step_d  = cur_step_q;
    e_d         = e_q;
    started_d   = started_q;
    glide_d     = glide_q;
    sine_d      = sine_q;
    cos_d       = cos_q;
    prod_d      = prod_q;
    num_d       = num_q;
    dcount_d    = dcount_q;
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    out_d       = out_q;
    case (state_q)
      S_IDLE: begin
        if (accept && len_sat != '0) begin
          len_d    = len_sat;
          sil_d    = silent;
          span_d   = len_sat - silent;
          step_d   = in_data_i.step_factor;
          idx_d    = '0;
          dcount_d = dcount_q + DLW'(silent);
          state_d  = (silent != '0) ? S_SILENT : S_PREP;
        end
      end
      S_SILENT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.sample = '0;
          out_d.last   = is_last;
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
            if (CW'(idx_q + 1'b1) == sil_q) begin
              state_d = S_PREP;
            end
          end
        end
      end
      S_PREP: begin
        if (!started_q) begin
          started_d  = 1'b1;
          cur_step_d = step_q;
          sine_d     = cfg_i.start_sine;
          cos_d      = cfg_i.start_cosine;
          old_d      = step_q;
          glide_d    = 1'b0;
        end else begin
          old_d   = cur_step_q;
          glide_d = cur_step_q != step_q;
        end
        state_d = S_SPAN;
      end
      S_SPAN: begin
        prod_d  = mul_p;
        state_d = S_NUMI;
      end
      S_NUMI: begin
        num_d   = prod_q[NW-1:0];
        state_d = S_SAMPLE;
      end
      S_SAMPLE: begin
        if (glide_q) begin
          state_d = S_DIV;
        end else begin
          e_d     = old_q;
          state_d = S_MULS;
        end
      end
      S_DIV: begin
        if (div_done) begin
          e_d     = div_quo[SW-1:0];
          state_d = S_MULS;
        end
      end
      S_MULS: begin
        prod_d  = mul_p;
        state_d = S_UPDC;
      end
      S_UPDC: begin
        cos_d   = sat32($signed({{4{cos_q[DWD-1]}}, cos_q}) - $signed({scaled[PW-31], scaled}));
        state_d = S_MULC;
      end
      S_MULC: begin
        prod_d  = mul_p;
        state_d = S_UPDS;
      end
      S_UPDS: begin
        sine_d  = sat32($signed({{4{sine_q[DWD-1]}}, sine_q}) + $signed({scaled[PW-31], scaled}));
        num_d   = num_q + NW'(step_q) - NW'(old_q);
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d.sample = sine_q;
          out_d.last   = is_last;
          if (is_last) begin
            cur_step_d = step_q;
            state_d    = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_SAMPLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= 1'b0;
      cur_step_q  <= '0;
      sine_q      <= '0;
      cos_q       <= '0;
      dcount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      cur_step_q  <= cur_step_d;
      sine_q      <= sine_d;
      cos_q       <= cos_d;
      dcount_q    <= dcount_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    len_q   <= len_d;
    sil_q   <= sil_d;
    span_q  <= span_d;
    step_q  <= step_d;
    old_q   <= old_d;
    e_q     <= e_d;
    glide_q <= glide_d;
    prod_q  <= prod_d;
    num_q   <= num_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/quadrature_oscillator_with_glide_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_oscillator_with_glide_top: block-based magic circle oscillator
// Holds the configuration registers and the oscillator sequencer.
// ----------------------------------------------------------------------------
// Each request on the input channel asks for one block of block_len samples
// (1 to BLOCK_MAX, larger values are clipped, zero is dropped) at the step
// factor step_factor. The block answers with block_len samples on the output
// channel, the final one flagged by last. Samples stay zero until
// delay_samples silent samples have gone out since reset.
// A sounding sample passes the shared multiplier twice, once per phase
// update; while the step factor glides it first waits on the bit-serial
// division of an NW-bit numerator, NW = clog2(BLOCK_MAX + 1) + 32. The
// sounding part of a block starts with the setup states PREP, SPAN and NUMI.
// The input stall stays high from the accepted request until the last sample
// has been loaded into the output register. When the receiver stalls, the
// held sample waits and the sequencer pauses in front of the next one.
// Reset clears the delay count, the phase registers and the configuration
// to its defaults. The configuration port is always ready; it must be
// written by the user between blocks only; the block does not enforce it.
// ----------------------------------------------------------------------------
module quadrature_oscillator_with_glide_top #(
  parameter int BLOCK_MAX = qog_pkg::BLOCK_MAX_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [qog_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [qog_pkg::DATA_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  qog_pkg::qog_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output qog_pkg::qog_out_t               out_data_o
);

  qog_pkg::qog_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_samples <= qog_pkg::DELAY_RESET;
      cfg_q.start_sine    <= qog_pkg::START_SINE_RESET;
      cfg_q.start_cosine  <= qog_pkg::START_COSINE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        qog_pkg::REG_DELAY: begin
          cfg_q.delay_samples <= cfg_data_i[qog_pkg::DELAY_W-1:0];
        end
        qog_pkg::REG_START_SINE: begin
          cfg_q.start_sine <= $signed(cfg_data_i);
        end
        qog_pkg::REG_START_COSINE: begin
          cfg_q.start_cosine <= $signed(cfg_data_i);
        end
        default: begin
        end
      endcase
    end
  end

  qog_core #(
    .BLOCK_MAX(BLOCK_MAX)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.block_len != '0 |=> in_stall_o)
    else $error("block did not become busy after a nonempty request");

  a_busy_mid_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |-> in_stall_o)
    else $error("block took a request before the current block ended");

  a_idle_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && $past(!in_stall_o) && $past(rst_ni) |-> !$rose(out_valid_o))
    else $error("sample appeared while the block stayed idle");
`endif

endmodule
